@@ rtl/acbr_pkg.sv @@
// shared types, constants and descriptor lookup for the board configuration space
`timescale 1ns / 1ps
`default_nettype none

package acbr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_TYPE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRODUCT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAGS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUFACTURER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SERIAL       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAG         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE         = 3'd6;

    localparam logic [15:0] OFS_BASE_HI = 16'h0048;
    localparam logic [15:0] OFS_BASE_LO = 16'h004A;
    localparam logic [7:0]  OFS_IRQ_A   = 8'h40;
    localparam logic [7:0]  OFS_IRQ_B   = 8'h42;
    localparam logic [7:0]  NIBBLE_MASK = 8'hF0;
    localparam logic [7:0]  BYTE_IDLE   = 8'hFF;

    typedef struct packed {
        logic [7:0]  board_type_bits;
        logic [7:0]  product_code;
        logic [7:0]  board_flags;
        logic [15:0] manufacturer_code;
        logic [31:0] serial_number;
        logic [15:0] diag_vector;
        logic [2:0]  size_log2_pages;
    } t_cfg;

    typedef struct packed {
        logic        req_type;
        logic [15:0] addr_offset;
        logic [7:0]  write_data;
    } t_req;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        board_active;
        logic [23:0] base_address;
    } t_rsp;

    // descriptor byte by index; bytes 3 and 12..15 read as zero
    function automatic logic [7:0] desc_byte(input t_cfg cfg, input logic [3:0] idx);
        logic [2:0] size_code;
        logic [7:0] d;
        size_code = cfg.size_log2_pages + 3'd1;
        case (idx)
            4'h0:    d = cfg.board_type_bits | {5'd0, size_code};
            4'h1:    d = cfg.product_code;
            4'h2:    d = cfg.board_flags;
            4'h4:    d = cfg.manufacturer_code[15:8];
            4'h5:    d = cfg.manufacturer_code[7:0];
            4'h6:    d = cfg.serial_number[31:24];
            4'h7:    d = cfg.serial_number[23:16];
            4'h8:    d = cfg.serial_number[15:8];
            4'h9:    d = cfg.serial_number[7:0];
            4'hA:    d = cfg.diag_vector[15:8];
            4'hB:    d = cfg.diag_vector[7:0];
            default: d = 8'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/autoconfig_board_registers_unit.sv @@
// top level of the expansion board configuration register space
`timescale 1ns / 1ps
`default_nettype none

// Configuration window of an expansion board. Each request is a read or write
// of one offset; every request gives one response carrying the read byte, the
// active flag and the 24-bit base address after the request. A request goes
// through a request register and a response register; one request is taken every
// cycle while the response side keeps up, as the single pass from request register
// to response register sets. The user must set descriptor fields through the write
// port while no request is in flight; the block itself does not enforce it.
module autoconfig_board_registers_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_req_valid,
    output logic                                 o_req_ready,
    input  wire acbr_pkg::t_req                  i_req,
    output logic                                 o_rsp_valid,
    input  wire logic                            i_rsp_ready,
    output acbr_pkg::t_rsp                       o_rsp,
    input  wire logic                            i_cfg_we,
    input  wire logic [acbr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [acbr_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import acbr_pkg::*;

    t_cfg w_cfg;

    acbr_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    acbr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

@@ rtl/acbr_cfg_regs.sv @@
// configuration register file written through the plain write port
`timescale 1ns / 1ps
`default_nettype none

module acbr_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [acbr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [acbr_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output acbr_pkg::t_cfg                       o_cfg
);
    import acbr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BOARD_TYPE:   r_cfg.board_type_bits   <= i_cfg_wdata[7:0];
                CFG_PRODUCT:      r_cfg.product_code      <= i_cfg_wdata[7:0];
                CFG_FLAGS:        r_cfg.board_flags       <= i_cfg_wdata[7:0];
                CFG_MANUFACTURER: r_cfg.manufacturer_code <= i_cfg_wdata[15:0];
                CFG_SERIAL:       r_cfg.serial_number     <= i_cfg_wdata[31:0];
                CFG_DIAG:         r_cfg.diag_vector       <= i_cfg_wdata[15:0];
                CFG_SIZE:         r_cfg.size_log2_pages   <= i_cfg_wdata[2:0];
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/acbr_read_decode.sv @@
// read decode of the configuration window: nibble select, inversion, zero interrupt bytes and idle fill
`timescale 1ns / 1ps
`default_nettype none

module acbr_read_decode (
    input  wire acbr_pkg::t_cfg i_cfg,
    input  wire logic [7:0]     i_offset,
    output logic [7:0]          o_data
);
    import acbr_pkg::*;

    logic [7:0] w_desc;
    logic [3:0] w_nib;
    logic [7:0] w_val;

    assign w_desc = desc_byte(i_cfg, i_offset[5:2]);
    assign w_nib  = i_offset[1] ? w_desc[3:0] : w_desc[7:4];
    assign w_val  = {w_nib, 4'd0};

    always_comb begin
        if (!i_offset[0] && (i_offset < 8'h40)) begin
            // only the first descriptor byte reads true, the rest inverted
            o_data = (i_offset < 8'h04) ? w_val : ~w_val;
        end else if ((i_offset == OFS_IRQ_A) || (i_offset == OFS_IRQ_B)) begin
            o_data = 8'd0;
        end else begin
            o_data = BYTE_IDLE;
        end
    end

endmodule

`default_nettype wire

@@ rtl/acbr_core.sv @@
// request register, base address state and response register
`timescale 1ns / 1ps
`default_nettype none

module acbr_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire acbr_pkg::t_cfg i_cfg,
    input  wire logic           i_req_valid,
    output logic                o_req_ready,
    input  wire acbr_pkg::t_req i_req,
    output logic                o_rsp_valid,
    input  wire logic           i_rsp_ready,
    output acbr_pkg::t_rsp      o_rsp
);
    import acbr_pkg::*;

    logic        r_in_valid;
    t_req        r_in;
    logic        r_rsp_valid;
    t_rsp        r_rsp;
    logic [23:0] r_base;
    logic        r_active;

    logic        w_adv;
    logic        w_move;
    logic [23:0] n_base;
    logic        n_active;
    logic [7:0]  w_rd;
    logic [7:0]  w_nib;

    assign w_adv       = !r_rsp_valid || i_rsp_ready;
    assign w_move      = r_in_valid && w_adv;
    assign o_req_ready = !r_in_valid || w_adv;

    acbr_read_decode u_read_decode (
        .i_cfg    (i_cfg),
        .i_offset (r_in.addr_offset[7:0]),
        .o_data   (w_rd)
    );

    assign w_nib = r_in.write_data & NIBBLE_MASK;

    always_comb begin
        n_base   = r_base;
        n_active = r_active;
        if (r_in.req_type) begin
            if (r_in.addr_offset == OFS_BASE_HI) begin
                n_base[23:20] = r_base[23:20] | w_nib[7:4];
                n_active      = 1'b1;
            end else if (r_in.addr_offset == OFS_BASE_LO) begin
                n_base[19:16] = r_base[19:16] | w_nib[7:4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_rsp_valid <= 1'b0;
            r_base      <= '0;
            r_active    <= 1'b0;
        end else begin
            if (o_req_ready) begin
                r_in_valid <= i_req_valid;
            end
            if (w_adv) begin
                r_rsp_valid <= r_in_valid;
            end
            if (w_move) begin
                r_base   <= n_base;
                r_active <= n_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_in <= i_req;
        end
        if (w_move) begin
            r_rsp.read_data    <= r_in.req_type ? 8'd0 : w_rd;
            r_rsp.board_active <= n_active;
            r_rsp.base_address <= n_base;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

`ifndef SYNTHESIS
    a_active_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |=> r_active)
        else $error("board active flag dropped");

    a_base_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((r_base & $past(r_base)) == $past(r_base)))
        else $error("base address bit cleared");

    a_rsp_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> (r_rsp.base_address == r_base) && (r_rsp.board_active == r_active))
        else $error("response does not match state after request");

    a_write_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && r_in.req_type) |=> (r_rsp.read_data == 8'd0))
        else $error("write request returned nonzero read data");
`endif

endmodule

`default_nettype wire
